### design/qoienc_pkg.sv
`timescale 1ns / 1ps
// qoienc_pkg: shared constants and types for the QOI pixel encoder.
// Used by qoienc_outq and qoi_pixel_encoder; no dependencies.

package qoienc_pkg;

  localparam int CACHE_ENTRIES = 64;
  localparam int MAX_BYTES     = 14;
  localparam int COUNT_W       = $clog2(MAX_BYTES + 1);

  localparam logic [7:0] OP_RGB  = 8'hFE;
  localparam logic [7:0] OP_RGBA = 8'hFF;
  localparam logic [7:0] OP_RUN  = 8'hC0;
  localparam logic [7:0] OP_DIFF = 8'h40;
  localparam logic [7:0] OP_LUMA = 8'h80;

  localparam logic [5:0] RUN_LIMIT = 6'd62;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  localparam logic [7:0] END_PAD [8] = '{8'h00, 8'h00, 8'h00, 8'h00,
                                         8'h00, 8'h00, 8'h00, 8'h01};

  // all bytes one pixel causes, in stream order
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [COUNT_W-1:0]        count;
  } rec_t;

endpackage

### design/qoienc_ram.sv
`timescale 1ns / 1ps
// qoienc_ram: generic single write port, single read port RAM, registered read.
// No dependencies.

module qoienc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/qoienc_outq.sv
`timescale 1ns / 1ps
// qoienc_outq: two-deep queue of per-pixel byte records, serialized one byte a word.
// Depends on qoienc_pkg.

module qoienc_outq (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  qoienc_pkg::rec_t  push_rec,
  output logic              full,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              last_of_item
);

  localparam int IDX_W = $clog2(qoienc_pkg::MAX_BYTES);

  qoienc_pkg::rec_t  slots [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        cnt;
  logic [IDX_W-1:0]  idx;
  logic              pop;
  qoienc_pkg::rec_t  head;

  assign head         = slots[rd_ptr];
  assign full         = (cnt == 2'd2);
  assign out_valid    = (cnt != 2'd0);
  assign out_byte     = head.bytes[idx];
  assign last_of_item = (qoienc_pkg::COUNT_W'(idx) == head.count - 1'b1);
  assign pop          = out_valid && out_ready && last_of_item;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
      idx    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (out_valid && out_ready) begin
        if (last_of_item) begin
          idx    <= '0;
          rd_ptr <= ~rd_ptr;
        end else begin
          idx <= idx + 1'b1;
        end
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

### design/qoi_pixel_encoder.sv
`timescale 1ns / 1ps
// qoi_pixel_encoder: QOI op-byte encoder, one pixel per word, header not written.
// Depends on qoienc_pkg, qoienc_ram, qoienc_outq.

// Usage:
//   Pixel channel (in_valid/in_ready): red, green, blue, alpha, final_pixel.
//   Byte channel (out_valid/out_ready): out_byte, last_of_item marks the
//   final byte a pixel caused. A pixel that only extends a run gives none.
//   Config channel (cfg_valid/cfg_ready, always ready): alpha_enabled;
//   write only while no pixel is in flight.
// Timing: a pixel is registered on accept while its cache slot is read from
//   the color RAM; the encode stage then encodes it and pushes its bytes into
//   the registered output queue. One pixel per cycle is taken while the
//   output keeps up; sustained rate is set by the byte port, one byte per
//   cycle while out_ready is high.
// Reset: previous pixel 0,0,0,255, run 0, cache valid bits cleared (empty
//   entries read as zero), alpha_enabled 1. Encoding the final pixel queues
//   8 bytes of end padding and restores all of this state but alpha_enabled.
// Stall: a two-record output queue absorbs back pressure; when it is full
//   the encode stage holds and in_ready drops.

module qoi_pixel_encoder #(
  parameter int CACHE_ENTRIES = qoienc_pkg::CACHE_ENTRIES
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  logic [7:0] alpha,
  input  logic       final_pixel,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last_of_item,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       alpha_enabled
);

  localparam int SLOT_W = $clog2(CACHE_ENTRIES);

  logic alpha_en;

  // encode stage register
  logic              p_valid;
  logic [7:0]        p_r, p_g, p_b, p_a;
  logic              p_last;
  logic [SLOT_W-1:0] p_slot;

  // previous pixel and run
  logic [7:0] prev_r, prev_g, prev_b, prev_a;
  logic [5:0] run_length;

  logic [CACHE_ENTRIES-1:0] cache_valid;
  logic                     fwd_valid;
  logic [SLOT_W-1:0]        fwd_slot;
  logic [31:0]              fwd_data;
  logic [31:0]              ram_rdata;

  logic              accept;
  logic              process;
  logic              q_full;
  logic [7:0]        in_a;
  logic [12:0]       hash_sum;
  logic [SLOT_W-1:0] in_slot;

  logic        same;
  logic [31:0] packed_px;
  logic [31:0] entry;
  logic        cache_we;
  logic [5:0]  run_inc;
  logic [5:0]  run_length_next;
  logic        run_emit;
  logic [7:0]  run_byte;
  logic [4:0][7:0] op;
  logic [2:0]  op_len;
  logic [7:0]  dr, dg, db, drg, dbg;
  logic [7:0]  dr2, dg2, db2, dg32, drg8, dbg8;
  qoienc_pkg::rec_t rec;
  logic [4:0]  pos_j;
  logic [4:0]  pos_k;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign process   = p_valid && !q_full;
  assign in_ready  = !p_valid || process;

  assign in_a     = alpha_en ? alpha : qoienc_pkg::ALPHA_OPAQUE;
  assign hash_sum = 13'(red) * 13'd3 + 13'(green) * 13'd5 + 13'(blue) * 13'd7
                  + 13'(in_a) * 13'd11;
  assign in_slot  = hash_sum[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_en <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      alpha_en <= alpha_enabled;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (accept) begin
      p_valid <= 1'b1;
    end else if (process) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_r    <= red;
      p_g    <= green;
      p_b    <= blue;
      p_a    <= in_a;
      p_last <= final_pixel;
      p_slot <= in_slot;
    end
  end

  qoienc_ram #(
    .WIDTH (32),
    .DEPTH (CACHE_ENTRIES)
  ) u_cache (
    .clk   (clk),
    .we    (cache_we),
    .waddr (p_slot),
    .wdata (packed_px),
    .re    (accept),
    .raddr (in_slot),
    .rdata (ram_rdata)
  );

  // RAM read races a write on the same edge; forward that write
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (accept) begin
      fwd_valid <= cache_we && !p_last;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_slot <= p_slot;
      fwd_data <= packed_px;
    end
  end

  always_comb begin
    packed_px = {p_r, p_g, p_b, p_a};
    same      = (packed_px == {prev_r, prev_g, prev_b, prev_a});
    cache_we  = process && !same;

    if (fwd_valid && fwd_slot == p_slot) begin
      entry = fwd_data;
    end else if (cache_valid[p_slot]) begin
      entry = ram_rdata;
    end else begin
      entry = '0;
    end

    dr   = p_r - prev_r;
    dg   = p_g - prev_g;
    db   = p_b - prev_b;
    drg  = dr - dg;
    dbg  = db - dg;
    dr2  = dr + 8'd2;
    dg2  = dg + 8'd2;
    db2  = db + 8'd2;
    dg32 = dg + 8'd32;
    drg8 = drg + 8'd8;
    dbg8 = dbg + 8'd8;

    run_inc         = run_length + 1'b1;
    run_emit        = 1'b0;
    run_byte        = '0;
    run_length_next = run_length;
    op              = '0;
    op_len          = '0;

    if (same) begin
      if (run_inc == qoienc_pkg::RUN_LIMIT || p_last) begin
        run_emit        = 1'b1;
        run_byte        = qoienc_pkg::OP_RUN | {2'b00, run_length};
        run_length_next = '0;
      end else begin
        run_length_next = run_inc;
      end
    end else begin
      run_emit        = (run_length != 6'd0);
      run_byte        = qoienc_pkg::OP_RUN | {2'b00, run_length - 1'b1};
      run_length_next = '0;
      if (entry == packed_px) begin
        op[0]  = 8'(p_slot);
        op_len = 3'd1;
      end else if (p_a == prev_a) begin
        if (dr2 < 8'd4 && dg2 < 8'd4 && db2 < 8'd4) begin
          op[0]  = qoienc_pkg::OP_DIFF | {2'b00, dr2[1:0], dg2[1:0], db2[1:0]};
          op_len = 3'd1;
        end else if (dg32 < 8'd64 && drg8 < 8'd16 && dbg8 < 8'd16) begin
          op[0]  = qoienc_pkg::OP_LUMA | {2'b00, dg32[5:0]};
          op[1]  = {drg8[3:0], dbg8[3:0]};
          op_len = 3'd2;
        end else begin
          op[0]  = qoienc_pkg::OP_RGB;
          op[1]  = p_r;
          op[2]  = p_g;
          op[3]  = p_b;
          op_len = 3'd4;
        end
      end else begin
        op[0]  = qoienc_pkg::OP_RGBA;
        op[1]  = p_r;
        op[2]  = p_g;
        op[3]  = p_b;
        op[4]  = p_a;
        op_len = 3'd5;
      end
    end
  end

  // lay out run byte, op bytes, then end padding
  always_comb begin
    pos_j = '0;
    pos_k = '0;
    for (int i = 0; i < qoienc_pkg::MAX_BYTES; i++) begin
      pos_j = 5'(i) - 5'(run_emit);
      pos_k = pos_j - 5'(op_len);
      if (run_emit && i == 0) begin
        rec.bytes[i] = run_byte;
      end else if (pos_j < 5'(op_len)) begin
        rec.bytes[i] = op[pos_j[2:0]];
      end else begin
        rec.bytes[i] = qoienc_pkg::END_PAD[pos_k[2:0]];
      end
    end
    rec.count = qoienc_pkg::COUNT_W'(run_emit) + qoienc_pkg::COUNT_W'(op_len)
              + (p_last ? qoienc_pkg::COUNT_W'(8) : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_r      <= '0;
      prev_g      <= '0;
      prev_b      <= '0;
      prev_a      <= qoienc_pkg::ALPHA_OPAQUE;
      run_length  <= '0;
      cache_valid <= '0;
    end else if (process) begin
      if (p_last) begin
        prev_r      <= '0;
        prev_g      <= '0;
        prev_b      <= '0;
        prev_a      <= qoienc_pkg::ALPHA_OPAQUE;
        run_length  <= '0;
        cache_valid <= '0;
      end else begin
        run_length <= run_length_next;
        if (!same) begin
          prev_r              <= p_r;
          prev_g              <= p_g;
          prev_b              <= p_b;
          prev_a              <= p_a;
          cache_valid[p_slot] <= 1'b1;
        end
      end
    end
  end

  qoienc_outq u_outq (
    .clk          (clk),
    .rst          (rst),
    .push         (process && rec.count != '0),
    .push_rec     (rec),
    .full         (q_full),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .last_of_item (last_of_item)
  );

endmodule

### tb/tb_qoi_pixel_encoder.sv
`timescale 1ns / 1ps
// tb_qoi_pixel_encoder: self-checking bench for the QOI pixel encoder; predicts every byte.
// Depends on qoienc_pkg and qoi_pixel_encoder; directed, run-limit, back-pressure, random tests.

module tb_qoi_pixel_encoder;

  localparam int CLK_PERIOD    = 12;
  localparam int SETTLE_CYCLES = 6;
  localparam int MAX_PRINTS    = 50;

  typedef struct {
    logic [7:0] value;
    logic       last;
  } coded_byte_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       final_pixel;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       last_of_item;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       alpha_enabled;

  // predicted stream and predictor state
  coded_byte_t byte_q[$];
  logic        alpha_on;
  logic [31:0] prev_px;
  logic [5:0]  run_len;
  logic [31:0] color_cache [qoienc_pkg::CACHE_ENTRIES];

  int errors;
  int byte_idx;
  bit steady;
  int hold_left;

  qoi_pixel_encoder uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .alpha        (alpha),
    .final_pixel  (final_pixel),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .last_of_item (last_of_item),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .alpha_enabled(alpha_enabled)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(CLK_PERIOD * 100000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic void clear_history();
    prev_px = {24'h0, qoienc_pkg::ALPHA_OPAQUE};
    run_len = '0;
    foreach (color_cache[i]) color_cache[i] = '0;
  endfunction

  function automatic void push_byte(input logic [7:0] v);
    coded_byte_t cb;
    cb.value = v;
    cb.last  = 1'b0;
    byte_q.push_back(cb);
  endfunction

  // op selection order: run, index, diff, luma, full color
  function automatic void encode_pixel(input logic [7:0] r, g, b, a_in, input logic fin);
    logic [7:0]        a;
    logic [5:0]        slot;
    logic [31:0]       px;
    logic signed [7:0] dr, dg, db, drg, dbg;
    int                first;
    int                i;
    coded_byte_t       tail;
    first = byte_q.size();
    a  = alpha_on ? a_in : qoienc_pkg::ALPHA_OPAQUE;
    px = {r, g, b, a};
    if (px == prev_px) begin
      run_len = run_len + 6'd1;
      if (run_len == qoienc_pkg::RUN_LIMIT || fin) begin
        push_byte(qoienc_pkg::OP_RUN | {2'b00, run_len - 6'd1});
        run_len = '0;
      end
    end else begin
      slot = 6'(3 * r + 5 * g + 7 * b + 11 * a);
      if (run_len != 0) begin
        push_byte(qoienc_pkg::OP_RUN | {2'b00, run_len - 6'd1});
        run_len = '0;
      end
      if (color_cache[slot] == px) begin
        push_byte({2'b00, slot});
      end else if (a == prev_px[7:0]) begin
        // channel deltas wrap mod 256, read as signed
        dr  = r - prev_px[31:24];
        dg  = g - prev_px[23:16];
        db  = b - prev_px[15:8];
        drg = dr - dg;
        dbg = db - dg;
        if (dr >= -2 && dr <= 1 && dg >= -2 && dg <= 1 && db >= -2 && db <= 1) begin
          push_byte(qoienc_pkg::OP_DIFF | {2'b00, 2'(dr + 2), 2'(dg + 2), 2'(db + 2)});
        end else if (dg >= -32 && dg <= 31 && drg >= -8 && drg <= 7 &&
                     dbg >= -8 && dbg <= 7) begin
          push_byte(qoienc_pkg::OP_LUMA | {2'b00, 6'(dg + 32)});
          push_byte({4'(drg + 8), 4'(dbg + 8)});
        end else begin
          push_byte(qoienc_pkg::OP_RGB);
          push_byte(r);
          push_byte(g);
          push_byte(b);
        end
      end else begin
        push_byte(qoienc_pkg::OP_RGBA);
        push_byte(r);
        push_byte(g);
        push_byte(b);
        push_byte(a);
      end
      color_cache[slot] = px;
      prev_px = px;
    end
    if (fin) begin
      for (i = 0; i < 8; i++) push_byte(qoienc_pkg::END_PAD[i]);
      clear_history();
    end
    if (byte_q.size() > first) begin
      tail = byte_q.pop_back();
      tail.last = 1'b1;
      byte_q.push_back(tail);
    end
  endfunction

  task automatic flag_mismatch(input string what, input logic [7:0] got,
                               input logic [7:0] want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("%0t: byte %0d %s got %02h want %02h", $realtime, byte_idx, what, got, want);
  endtask

  // valid stays up after accept; next call either reuses it or idles first
  task automatic send_pixel(input logic [7:0] r, g, b, a, input logic fin);
    while (!steady && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    red         <= r;
    green       <= g;
    blue        <= b;
    alpha       <= a;
    final_pixel <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    encode_pixel(r, g, b, a, fin);
  endtask

  // idle the input, wait out every predicted byte plus pipeline slack
  task automatic drain_bytes();
    in_valid <= 1'b0;
    while (byte_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_alpha_mode(input logic on);
    cfg_valid     <= 1'b1;
    alpha_enabled <= on;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    alpha_on = on;
    cfg_valid <= 1'b0;
  endtask

  // byte side: random ready, optional long hold, checking
  always @(posedge clk) begin : byte_side
    coded_byte_t want;
    if (!rst && out_valid && out_ready) begin
      if (byte_q.size() == 0) begin
        flag_mismatch("unexpected byte", out_byte, 8'h00);
      end else begin
        want = byte_q.pop_front();
        if (out_byte !== want.value) flag_mismatch("out_byte", out_byte, want.value);
        if (last_of_item !== want.last)
          flag_mismatch("last_of_item", {7'd0, last_of_item}, {7'd0, want.last});
      end
      byte_idx++;
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= 15);
    end
  end

  task automatic test_directed_ops();
    write_alpha_mode(1'b1);
    send_pixel(0, 0, 0, 255, 0);        // repeats reset color: no bytes
    send_pixel(0, 0, 0, 255, 0);
    send_pixel(0, 0, 0, 0, 0);          // run flush, then transparent black hits slot 0
    send_pixel(1, 1, 1, 0, 0);          // diff +1
    send_pixel(255, 255, 255, 0, 0);    // diff -2 with wrap
    send_pixel(20, 20, 20, 0, 0);       // luma
    send_pixel(200, 10, 90, 0, 0);      // rgb
    send_pixel(200, 10, 90, 128, 0);    // rgba
    send_pixel(20, 20, 20, 0, 0);       // index
    send_pixel(255, 255, 255, 255, 0);
    send_pixel(0, 0, 0, 255, 0);
    send_pixel(0, 0, 0, 255, 1);        // final repeat flushes run
    send_pixel(0, 0, 0, 255, 1);        // one-pixel image, run of one
    send_pixel(128, 127, 1, 255, 1);    // final new color
    send_pixel(23, 31, 38, 255, 0);     // luma extremes: dg +31, dr-dg -8, db-dg +7
    send_pixel(254, 255, 254, 255, 0);  // luma extremes, wrapped: dg -32, dr-dg +7, db-dg -8
    send_pixel(255, 0, 255, 0, 1);
    drain_bytes();
  endtask

  task automatic test_three_channel();
    write_alpha_mode(1'b0);
    send_pixel(0, 0, 0, 7, 0);          // alpha ignored, so this is a run
    send_pixel(0, 0, 0, 200, 0);
    send_pixel(5, 5, 5, 0, 0);
    send_pixel(255, 128, 0, 99, 0);
    send_pixel(255, 128, 0, 0, 1);
    drain_bytes();
    write_alpha_mode(1'b1);
  endtask

  // long stretch with no idling on either side
  task automatic test_run_limit();
    int extra;
    extra = $urandom_range(1, 3);
    steady = 1'b1;
    send_pixel(9, 9, 9, 255, 0);
    repeat (62 + extra) send_pixel(9, 9, 9, 255, 0);
    send_pixel(10, 9, 9, 255, 1);
    drain_bytes();
    steady = 1'b0;
  endtask

  task automatic test_output_backpressure();
    logic [7:0] r, g, b, a;
    int         i;
    hold_left = 300;
    for (i = 0; i < 16; i++) begin
      {r, g, b, a} = $urandom;
      send_pixel(r, g, b, a, i == 15);
    end
    drain_bytes();
  endtask

  // images of random length, mostly coherent color steps, mode changes in between
  task automatic test_random_images(input int n_pixels);
    int         sent;
    int         img_len;
    int         k;
    logic [7:0] r, g, b, a;
    logic [7:0] dg;
    sent = 0;
    while (sent < n_pixels) begin
      img_len = $urandom_range(1, 24);
      if ($urandom_range(3) == 0) begin
        drain_bytes();
        write_alpha_mode(1'($urandom_range(1)));
      end
      steady = ($urandom_range(3) == 0);
      for (k = 0; k < img_len; k++) begin
        {r, g, b, a} = prev_px;
        case ($urandom_range(9)) inside
          [0:1]: ;
          [2:3]: begin
            r = r + 8'($urandom_range(3)) - 8'd2;
            g = g + 8'($urandom_range(3)) - 8'd2;
            b = b + 8'($urandom_range(3)) - 8'd2;
          end
          [4:5]: begin
            dg = 8'($urandom_range(63)) - 8'd32;
            g = g + dg;
            r = r + dg + 8'($urandom_range(15)) - 8'd8;
            b = b + dg + 8'($urandom_range(15)) - 8'd8;
          end
          6: {r, g, b, a} = color_cache[$urandom_range(qoienc_pkg::CACHE_ENTRIES - 1)];
          7: a = 8'($urandom);
          default: {r, g, b, a} = $urandom;
        endcase
        if (!alpha_on) a = 8'($urandom);
        send_pixel(r, g, b, a, k == img_len - 1);
        sent++;
      end
    end
    steady = 1'b0;
    drain_bytes();
  endtask

  initial begin
    rst           <= 1'b1;
    in_valid      <= 1'b0;
    red           <= '0;
    green         <= '0;
    blue          <= '0;
    alpha         <= '0;
    final_pixel   <= 1'b0;
    out_ready     <= 1'b0;
    cfg_valid     <= 1'b0;
    alpha_enabled <= 1'b1;
    alpha_on  = 1'b1;
    clear_history();
    errors    = 0;
    byte_idx  = 0;
    steady    = 1'b0;
    hold_left = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_ops();
    test_three_channel();
    test_run_limit();
    test_output_backpressure();
    test_random_images(60);

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
